>>> design/macro_token_parser_core_defines.svh
// Assertion macros for the macro token parser core.
`ifndef MACRO_TOKEN_PARSER_CORE_DEFINES_SVH
`define MACRO_TOKEN_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every edge outside reset.
`define MTP_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Check that a consequent holds whenever an antecedent holds.
`define MTP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define MTP_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define MTP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> design/mtp_pkg.sv
// Types and constants shared by the macro token parser core.
package mtp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_TOKEN,
        PH_CODE,
        PH_KEY,
        PH_DIGITS
    } phase_t;

    typedef enum logic [3:0] {
        TK_CHAR      = 4'd0,
        TK_TAP       = 4'd1,
        TK_DOWN      = 4'd2,
        TK_UP        = 4'd3,
        TK_DELAY     = 4'd4,
        TK_OTHER     = 4'd5,
        TK_DONE      = 4'd6,
        TK_MALFORMED = 4'd7,
        TK_NOTFOUND  = 4'd8,
        TK_REJECTED  = 4'd9
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [7:0]  code;
        logic [13:0] delay;
        logic        last;
    } tok_t;

    localparam logic IN_START = 1'b0;
    localparam logic IN_BYTE  = 1'b1;

    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_MACRO_COUNT = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_PREFIX_BYTE = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_TAP_CODE    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DOWN_CODE   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_UP_CODE     = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_DELAY_CODE  = 3'd5;

    localparam logic [7:0] RST_MACRO_COUNT = 8'd16;
    localparam logic [7:0] RST_PREFIX_BYTE = 8'd1;
    localparam logic [7:0] RST_TAP_CODE    = 8'd1;
    localparam logic [7:0] RST_DOWN_CODE   = 8'd2;
    localparam logic [7:0] RST_UP_CODE     = 8'd3;
    localparam logic [7:0] RST_DELAY_CODE  = 8'd4;

    localparam logic [13:0] DELAY_MAX   = 14'd9999;
    localparam logic [7:0]  DELAY_END   = 8'h7C;
    localparam logic [2:0]  DIGIT_LIMIT = 3'd4;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_NINE   = 8'h39;
    localparam logic [17:0] DIGIT_SCALE = 18'd10;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

>>> design/macro_token_parser_core.sv
// Top level of the macro token parser core.
// Results of an accepted item are written into the result queue the cycle after acceptance.
// Throughput: one item per cycle; each item writes up to two results into a
// four-entry result queue that drains one result per cycle while m_tready is high,
// and s_tready drops while fewer than two queue entries are free.
// Reset: synchronous active-low aresetn clears the parse state and the queue and
// loads the register defaults.
`include "macro_token_parser_core_defines.svh"

module macro_token_parser_core
    import mtp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // macro_id, data_byte
    input  logic                s_tuser,   // kind
    input  logic                s_tlast,   // final_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // token_code, delay_ms
    output logic [3:0]          m_tuser,   // token_kind
    output logic                m_tlast,   // last
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [7:0]          cfg_wdata
);

    logic [7:0] macro_count_reg, prefix_byte_reg, tap_code_reg;
    logic [7:0] down_code_reg, up_code_reg, delay_code_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  skip_left_reg, skip_left_next;
    logic [13:0] pending_delay_reg, pending_delay_next;
    logic [2:0]  digit_pos_reg, digit_pos_next;
    logic [13:0] digit_value_reg, digit_value_next;
    logic        digits_open_reg, digits_open_next;
    tok_kind_t   held_code_reg, held_code_next;

    tok_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    logic        in_acc, out_acc;
    logic [7:0]  macro_id, data_byte;
    logic        final_byte;
    logic        is_zero, is_digit, start_ok, final_bad;
    logic [7:0]  skip_dec;
    logic [14:0] delay_sum;
    logic [13:0] delay_sat;
    logic [17:0] digit_prod;
    logic [1:0]  push_n;
    tok_t        res0, res1;

    assign macro_id   = s_tdata[7:0];
    assign data_byte  = s_tdata[15:8];
    assign final_byte = s_tlast;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    assign is_zero   = (data_byte == 8'd0);
    assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign start_ok  = (phase_reg == PH_IDLE) && (macro_id < macro_count_reg);
    assign final_bad = final_byte && !((phase_reg == PH_TOKEN) && is_zero);
    assign skip_dec  = (is_zero && (skip_left_reg != 8'd0)) ? skip_left_reg - 8'd1
                                                            : skip_left_reg;
    assign delay_sum  = {1'b0, pending_delay_reg} + {1'b0, digit_value_reg};
    assign delay_sat  = (delay_sum > {1'b0, DELAY_MAX}) ? DELAY_MAX : delay_sum[13:0];
    assign digit_prod = 18'(digit_value_reg) * DIGIT_SCALE + 18'(data_byte - CHAR_ZERO);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            macro_count_reg <= RST_MACRO_COUNT;
            prefix_byte_reg <= RST_PREFIX_BYTE;
            tap_code_reg    <= RST_TAP_CODE;
            down_code_reg   <= RST_DOWN_CODE;
            up_code_reg     <= RST_UP_CODE;
            delay_code_reg  <= RST_DELAY_CODE;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MACRO_COUNT: macro_count_reg <= cfg_wdata;
                CFG_PREFIX_BYTE: prefix_byte_reg <= cfg_wdata;
                CFG_TAP_CODE:    tap_code_reg    <= cfg_wdata;
                CFG_DOWN_CODE:   down_code_reg   <= cfg_wdata;
                CFG_UP_CODE:     up_code_reg     <= cfg_wdata;
                CFG_DELAY_CODE:  delay_code_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic clear_run;
        clear_run          = 1'b0;
        phase_next         = phase_reg;
        skip_left_next     = skip_left_reg;
        pending_delay_next = pending_delay_reg;
        digit_pos_next     = digit_pos_reg;
        digit_value_next   = digit_value_reg;
        digits_open_next   = digits_open_reg;
        held_code_next     = held_code_reg;
        if (in_acc) begin
            if (s_tuser == IN_START) begin
                if (start_ok) begin
                    clear_run      = 1'b1;
                    phase_next     = (macro_id == 8'd0) ? PH_TOKEN : PH_SKIP;
                    skip_left_next = macro_id;
                end
            end else begin
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_SKIP: begin
                        skip_left_next = skip_dec;
                        phase_next     = (skip_dec == 8'd0) ? PH_TOKEN : PH_SKIP;
                        if (final_byte) begin
                            clear_run = 1'b1;
                        end
                    end
                    PH_TOKEN, PH_CODE, PH_KEY, PH_DIGITS: begin
                        if (final_bad) begin
                            clear_run = 1'b1;
                        end else begin
                            unique case (phase_reg)
                                PH_TOKEN: begin
                                    if (is_zero) begin
                                        clear_run = 1'b1;
                                    end else if (data_byte == prefix_byte_reg) begin
                                        phase_next = PH_CODE;
                                    end else begin
                                        pending_delay_next = 14'd0;
                                    end
                                end
                                PH_CODE: begin
                                    if (is_zero) begin
                                        clear_run = 1'b1;
                                    end else if (data_byte == tap_code_reg) begin
                                        held_code_next = TK_TAP;
                                        phase_next     = PH_KEY;
                                    end else if (data_byte == down_code_reg) begin
                                        held_code_next = TK_DOWN;
                                        phase_next     = PH_KEY;
                                    end else if (data_byte == up_code_reg) begin
                                        held_code_next = TK_UP;
                                        phase_next     = PH_KEY;
                                    end else if (data_byte == delay_code_reg) begin
                                        digit_pos_next   = 3'd0;
                                        digit_value_next = 14'd0;
                                        digits_open_next = 1'b1;
                                        phase_next       = PH_DIGITS;
                                    end else begin
                                        pending_delay_next = 14'd0;
                                        phase_next         = PH_TOKEN;
                                    end
                                end
                                PH_KEY: begin
                                    if (is_zero) begin
                                        clear_run = 1'b1;
                                    end else begin
                                        pending_delay_next = 14'd0;
                                        held_code_next     = TK_CHAR;
                                        phase_next         = PH_TOKEN;
                                    end
                                end
                                default: begin
                                    if (is_zero) begin
                                        clear_run = 1'b1;
                                    end else if (data_byte == DELAY_END) begin
                                        pending_delay_next = delay_sat;
                                        digit_pos_next     = 3'd0;
                                        digit_value_next   = 14'd0;
                                        digits_open_next   = 1'b0;
                                        phase_next         = PH_TOKEN;
                                    end else if (digit_pos_reg >= DIGIT_LIMIT) begin
                                        clear_run = 1'b1;
                                    end else begin
                                        if (digits_open_reg && is_digit) begin
                                            digit_value_next = digit_prod[13:0];
                                        end else begin
                                            digits_open_next = 1'b0;
                                        end
                                        digit_pos_next = digit_pos_reg + 3'd1;
                                    end
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (clear_run) begin
            if (!(in_acc && s_tuser == IN_START)) begin
                phase_next     = PH_IDLE;
                skip_left_next = 8'd0;
            end
            pending_delay_next = 14'd0;
            digit_pos_next     = 3'd0;
            digit_value_next   = 14'd0;
            digits_open_next   = 1'b0;
            held_code_next     = TK_CHAR;
        end
    end

    always_comb begin
        logic      single_v, token_v;
        tok_kind_t single_k, token_k;
        single_v = 1'b0;
        token_v  = 1'b0;
        single_k = TK_MALFORMED;
        token_k  = TK_CHAR;
        if (in_acc) begin
            if (s_tuser == IN_START) begin
                if (!start_ok) begin
                    single_v = 1'b1;
                    single_k = TK_REJECTED;
                end
            end else begin
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_SKIP: begin
                        if (final_byte) begin
                            single_v = 1'b1;
                            single_k = (skip_dec != 8'd0) ? TK_NOTFOUND : TK_MALFORMED;
                        end
                    end
                    PH_TOKEN, PH_CODE, PH_KEY, PH_DIGITS: begin
                        if (final_bad) begin
                            single_v = 1'b1;
                        end else begin
                            unique case (phase_reg)
                                PH_TOKEN: begin
                                    if (is_zero) begin
                                        single_v = 1'b1;
                                        single_k = TK_DONE;
                                    end else if (data_byte != prefix_byte_reg) begin
                                        token_v = 1'b1;
                                    end
                                end
                                PH_CODE: begin
                                    if (is_zero) begin
                                        single_v = 1'b1;
                                    end else if (data_byte != tap_code_reg &&
                                                 data_byte != down_code_reg &&
                                                 data_byte != up_code_reg &&
                                                 data_byte != delay_code_reg) begin
                                        token_v = 1'b1;
                                        token_k = TK_OTHER;
                                    end
                                end
                                PH_KEY: begin
                                    if (is_zero) begin
                                        single_v = 1'b1;
                                    end else begin
                                        token_v = 1'b1;
                                        token_k = held_code_reg;
                                    end
                                end
                                default: begin
                                    if (is_zero || (data_byte != DELAY_END &&
                                                    digit_pos_reg >= DIGIT_LIMIT)) begin
                                        single_v = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end

        res0   = '{kind: single_k, code: 8'd0, delay: 14'd0, last: 1'b1};
        res1   = '{kind: token_k, code: data_byte, delay: 14'd0, last: 1'b1};
        push_n = 2'd0;
        if (single_v) begin
            push_n = 2'd1;
        end else if (token_v) begin
            if (pending_delay_reg != 14'd0) begin
                res0   = '{kind: TK_DELAY, code: 8'd0, delay: pending_delay_reg, last: 1'b0};
                push_n = 2'd2;
            end else begin
                res0   = res1;
                push_n = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            skip_left_reg     <= 8'd0;
            pending_delay_reg <= 14'd0;
            digit_pos_reg     <= 3'd0;
            digit_value_reg   <= 14'd0;
            digits_open_reg   <= 1'b0;
            held_code_reg     <= TK_CHAR;
        end else begin
            phase_reg         <= phase_next;
            skip_left_reg     <= skip_left_next;
            pending_delay_reg <= pending_delay_next;
            digit_pos_reg     <= digit_pos_next;
            digit_value_reg   <= digit_value_next;
            digits_open_reg   <= digits_open_next;
            held_code_reg     <= held_code_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            fifo_mem[wr_ptr_reg + FIFO_AW'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_n);
            if (out_acc) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(out_acc);
        end
    end

    assign s_tready = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);
    assign m_tuser  = fifo_mem[rd_ptr_reg].kind;
    assign m_tdata  = {2'b00, fifo_mem[rd_ptr_reg].delay, fifo_mem[rd_ptr_reg].code};
    assign m_tlast  = fifo_mem[rd_ptr_reg].last;

    `MTP_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= (FIFO_AW+1)'(FIFO_DEPTH), "result queue overflow")
    `MTP_ASSERT_IMPLY(a_held_only_key, aclk, aresetn, phase_reg != PH_KEY, held_code_reg == TK_CHAR, "held code outside key phase")
    `MTP_ASSERT_ALWAYS(a_digit_pos_bound, aclk, aresetn, digit_pos_reg <= DIGIT_LIMIT, "delay character count out of range")
    `MTP_ASSERT_IMPLY(a_idle_clean, aclk, aresetn, phase_reg == PH_IDLE, pending_delay_reg == 14'd0 && skip_left_reg == 8'd0, "idle with leftover run state")
    `MTP_ASSERT_ALWAYS(a_delay_sat, aclk, aresetn, pending_delay_reg <= DELAY_MAX, "pending delay above saturation")

endmodule
